// ===== src/alrp_pkg.sv =====
// Package for the absolute-loader record parser.
// Holds the phase and event codes, the parser state and result types, and the
// stream constants. It depends on nothing.
`timescale 1ns / 1ps

package alrp_pkg;

	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_ZERO     = 4'd1,
		PH_ZERO_BAD = 4'd2,
		PH_CNT_LO   = 4'd3,
		PH_CNT_HI   = 4'd4,
		PH_ADR_LO   = 4'd5,
		PH_ADR_HI   = 4'd6,
		PH_DATA_LO  = 4'd7,
		PH_DATA_HI  = 4'd8,
		PH_CHECK    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		EV_WORD = 3'd0,
		EV_OK   = 3'd1,
		EV_END  = 3'd2,
		EV_HDR  = 3'd3,
		EV_ODD  = 3'd4,
		EV_SUM  = 3'd5
	} event_t;

	localparam logic [7:0]  START_BYTE = 8'd1;
	localparam logic [7:0]  END_BYTE   = 8'd2;
	localparam logic [15:0] HDR_BYTES  = 16'd6;
	localparam logic [15:0] ADDR_STEP  = 16'd2;
	localparam logic [15:0] GROUP_MASK = 16'd15;
	localparam logic [15:0] MIN_RESET  = 16'hFFFF;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  running_sum;
		logic [15:0] bytes_left;
		logic [15:0] current_address;
		logic [15:0] previous_address;
		logic        first_in_record;
		logic [7:0]  held_low_byte;
		logic [15:0] record_count;
		logic [15:0] min_seen;
		logic [15:0] max_seen;
		logic        halted;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:            PH_START,
		running_sum:      8'd0,
		bytes_left:       16'd0,
		current_address:  16'd0,
		previous_address: 16'd0,
		first_in_record:  1'b1,
		held_low_byte:    8'd0,
		record_count:     16'd0,
		min_seen:         MIN_RESET,
		max_seen:         16'd0,
		halted:           1'b0
	};

	typedef struct packed {
		logic        valid;
		event_t      event_res;
		logic [15:0] load_address;
		logic [15:0] word_value;
		logic        new_group;
		logic [15:0] record_number;
		logic [15:0] lowest_address;
		logic [15:0] highest_address;
		logic [7:0]  sum_residue;
	} result_t;

endpackage

// ===== src/alrp_ifs.sv =====
// Channel interfaces for the absolute-loader record parser: the byte input,
// the result output and the floor register write port.
// Depends on nothing but the field widths of the stream.
`timescale 1ns / 1ps

interface alrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface alrp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [15:0] load_address;
	logic [15:0] word_value;
	logic        new_group;
	logic [15:0] record_number;
	logic [15:0] lowest_address;
	logic [15:0] highest_address;
	logic [7:0]  sum_residue;

	modport source (output valid, output event_res, output load_address,
		output word_value, output new_group, output record_number,
		output lowest_address, output highest_address, output sum_residue,
		input ready);
	modport sink (input valid, input event_res, input load_address,
		input word_value, input new_group, input record_number,
		input lowest_address, input highest_address, input sum_residue,
		output ready);
endinterface

interface alrp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] min_address_floor;

	modport source (output valid, output min_address_floor, input ready);
	modport sink (input valid, input min_address_floor, output ready);
endinterface

// ===== src/alrp_step.sv =====
// Next-state and result logic of the record parser for one stream byte.
// Depends on alrp_pkg for the state, result and code definitions.
`timescale 1ns / 1ps

module alrp_step (
	input  alrp_pkg::state_t  cur,
	input  logic [7:0]        data_byte,
	input  logic [15:0]       floor,
	output alrp_pkg::state_t  nxt,
	output alrp_pkg::result_t res
);

	logic [7:0]  sum;
	logic [15:0] addr_full;
	logic [15:0] left_dec;
	logic [15:0] left_hdr;
	logic        word_grp;
	logic [15:0] word_min;
	logic [15:0] word_max;
	logic [15:0] word_val;
	logic        emit_word;

	assign sum       = ((cur.phase == alrp_pkg::PH_START) ? 8'd0 : cur.running_sum) + data_byte;
	assign addr_full = {data_byte, cur.current_address[7:0]};
	assign left_dec  = cur.bytes_left - 16'd1;
	assign left_hdr  = cur.bytes_left - alrp_pkg::HDR_BYTES;

	assign word_grp = ((cur.current_address & alrp_pkg::GROUP_MASK) == 16'd0)
		|| (cur.current_address != (cur.previous_address + alrp_pkg::ADDR_STEP))
		|| cur.first_in_record;
	assign word_min = ((cur.current_address < cur.min_seen) && (cur.current_address > floor))
		? cur.current_address : cur.min_seen;
	assign word_max = (cur.current_address > cur.max_seen) ? cur.current_address : cur.max_seen;

	always_comb begin
		nxt       = cur;
		emit_word = 1'b0;
		word_val  = 16'd0;
		res                 = '0;
		res.event_res       = alrp_pkg::EV_WORD;
		res.record_number   = cur.record_count;
		res.lowest_address  = cur.min_seen;
		res.highest_address = cur.max_seen;

		if (!cur.halted) begin
			nxt.running_sum = sum;
			unique case (cur.phase)
				alrp_pkg::PH_START: begin
					if (data_byte == alrp_pkg::END_BYTE) begin
						res.valid     = 1'b1;
						res.event_res = alrp_pkg::EV_END;
						nxt.halted    = 1'b1;
					end else begin
						nxt.phase = (data_byte == alrp_pkg::START_BYTE)
							? alrp_pkg::PH_ZERO : alrp_pkg::PH_ZERO_BAD;
					end
				end
				alrp_pkg::PH_ZERO, alrp_pkg::PH_ZERO_BAD: begin
					if ((cur.phase == alrp_pkg::PH_ZERO_BAD) || (data_byte != 8'd0)) begin
						res.valid     = 1'b1;
						res.event_res = alrp_pkg::EV_HDR;
						nxt.halted    = 1'b1;
					end else begin
						nxt.phase = alrp_pkg::PH_CNT_LO;
					end
				end
				alrp_pkg::PH_CNT_LO: begin
					nxt.bytes_left = {8'd0, data_byte};
					nxt.phase      = alrp_pkg::PH_CNT_HI;
				end
				alrp_pkg::PH_CNT_HI: begin
					nxt.bytes_left = {data_byte, cur.bytes_left[7:0]};
					nxt.phase      = alrp_pkg::PH_ADR_LO;
				end
				alrp_pkg::PH_ADR_LO: begin
					nxt.current_address = {8'd0, data_byte};
					nxt.phase           = alrp_pkg::PH_ADR_HI;
				end
				alrp_pkg::PH_ADR_HI: begin
					nxt.current_address = addr_full;
					if (addr_full[0]) begin
						res.valid     = 1'b1;
						res.event_res = alrp_pkg::EV_ODD;
						nxt.halted    = 1'b1;
					end else if (cur.bytes_left < alrp_pkg::HDR_BYTES) begin
						res.valid     = 1'b1;
						res.event_res = alrp_pkg::EV_HDR;
						nxt.halted    = 1'b1;
					end else begin
						nxt.bytes_left      = left_hdr;
						nxt.first_in_record = 1'b1;
						nxt.phase = (left_hdr != 16'd0) ? alrp_pkg::PH_DATA_LO : alrp_pkg::PH_CHECK;
					end
				end
				alrp_pkg::PH_DATA_LO: begin
					nxt.bytes_left = left_dec;
					if (left_dec == 16'd0) begin
						emit_word = 1'b1;
						word_val  = {8'd0, data_byte};
						nxt.phase = alrp_pkg::PH_CHECK;
					end else begin
						nxt.held_low_byte = data_byte;
						nxt.phase         = alrp_pkg::PH_DATA_HI;
					end
				end
				alrp_pkg::PH_DATA_HI: begin
					nxt.bytes_left = left_dec;
					emit_word      = 1'b1;
					word_val       = {data_byte, cur.held_low_byte};
					nxt.phase = (left_dec != 16'd0) ? alrp_pkg::PH_DATA_LO : alrp_pkg::PH_CHECK;
				end
				alrp_pkg::PH_CHECK: begin
					res.valid = 1'b1;
					if (sum != 8'd0) begin
						res.event_res   = alrp_pkg::EV_SUM;
						res.sum_residue = sum;
						nxt.halted      = 1'b1;
					end else begin
						res.event_res    = alrp_pkg::EV_OK;
						nxt.record_count = cur.record_count + 16'd1;
						nxt.phase        = alrp_pkg::PH_START;
					end
				end
				default: begin
					nxt.phase = alrp_pkg::PH_START;
				end
			endcase

			if (emit_word) begin
				nxt.min_seen         = word_min;
				nxt.max_seen         = word_max;
				nxt.previous_address = cur.current_address;
				nxt.current_address  = cur.current_address + alrp_pkg::ADDR_STEP;
				nxt.first_in_record  = 1'b0;
				res.valid            = 1'b1;
				res.event_res        = alrp_pkg::EV_WORD;
				res.load_address     = cur.current_address;
				res.word_value       = word_val;
				res.new_group        = word_grp;
				res.lowest_address   = word_min;
				res.highest_address  = word_max;
			end
		end
	end

endmodule

// ===== src/absolute_loader_record_parser.sv =====
// An accepted byte is registered in s1; its result passes the combinational step into s2.
// Throughput: one byte per cycle while no waiting result stalls the pipeline.
// A byte that makes no word or event gives no beat; a waiting result stalls only the s1 stage.
// Reset clears the parser state, the floor register and both valid flags at once.
// After stream end or an error the parser halts and drops every byte until reset.
// Depends on alrp_pkg, the channel interfaces and alrp_step.
`timescale 1ns / 1ps

module absolute_loader_record_parser (
	input  logic          clk,
	input  logic          arst_n,
	alrp_byte_if.sink     bytes,
	alrp_cfg_if.sink      cfg,
	alrp_res_if.source    results
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              res_valid_s2;
	alrp_pkg::result_t res_s2;
	alrp_pkg::state_t  state_q;
	alrp_pkg::state_t  state_nxt;
	alrp_pkg::result_t res_nxt;
	logic [15:0]       floor_q;
	logic              advance;

	assign advance     = !res_valid_s2 || results.ready;
	assign bytes.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	alrp_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.floor     (floor_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'd0;
		end else if (cfg.valid) begin
			floor_q <= cfg.min_address_floor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= alrp_pkg::STATE_RESET;
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1 && res_nxt.valid;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign results.valid           = res_valid_s2;
	assign results.event_res       = res_s2.event_res;
	assign results.load_address    = res_s2.load_address;
	assign results.word_value      = res_s2.word_value;
	assign results.new_group       = res_s2.new_group;
	assign results.record_number   = res_s2.record_number;
	assign results.lowest_address  = res_s2.lowest_address;
	assign results.highest_address = res_s2.highest_address;
	assign results.sum_residue     = res_s2.sum_residue;

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted |=> state_q.halted)
		else $error("parser left the halted state without reset");

	a_s1_free_takes_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes.ready)
		else $error("input stalled although the input stage is empty");

	a_event_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && (res_s2.event_res != alrp_pkg::EV_WORD))
		|-> ((res_s2.load_address == 16'd0) && (res_s2.word_value == 16'd0)
			&& !res_s2.new_group))
		else $error("non-word event carries word fields");

	a_word_within_max: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && (res_s2.event_res == alrp_pkg::EV_WORD))
		|-> (res_s2.highest_address >= res_s2.load_address))
		else $error("highest address below the emitted word address");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for absolute_loader_record_parser: it feeds loader byte streams,
// predicts every word and record event, and checks each result beat against that prediction.
// Depends on alrp_pkg, the channel interfaces and the parser top level.
`timescale 1ns / 1ps

typedef struct {
	alrp_pkg::event_t ev;
	logic [15:0]      addr;
	logic [15:0]      word;
	logic             grp;
	logic [15:0]      rec;
	logic [15:0]      lowest;
	logic [15:0]      highest;
	logic [7:0]       residue;
} loader_beat_t;

typedef enum int {
	STOP_END,
	STOP_BAD_FIRST,
	STOP_BAD_ZERO,
	STOP_SHORT,
	STOP_ODD,
	STOP_SUM
} stop_kind_t;

class record_parser_checker;
	logic [15:0]      floor_addr;
	alrp_pkg::phase_t stage;
	logic [7:0]       csum;
	logic [15:0]      remaining;
	logic [15:0]      word_addr;
	logic [15:0]      last_addr;
	logic             record_first;
	logic [7:0]       low_half;
	logic [15:0]      records_done;
	logic [15:0]      lowest;
	logic [15:0]      highest;
	logic             stopped;
	loader_beat_t     due[$];
	int               errors;

	function new();
		floor_addr = 16'd0;
		stage = alrp_pkg::PH_START;
		csum = 8'd0;
		remaining = 16'd0;
		word_addr = 16'd0;
		last_addr = 16'd0;
		record_first = 1'b1;
		low_half = 8'd0;
		records_done = 16'd0;
		lowest = alrp_pkg::MIN_RESET;
		highest = 16'd0;
		stopped = 1'b0;
		errors = 0;
	endfunction

	function void push_event(alrp_pkg::event_t ev, logic [7:0] residue);
		loader_beat_t b;
		b.ev = ev;
		b.addr = 16'd0;
		b.word = 16'd0;
		b.grp = 1'b0;
		b.rec = records_done;
		b.lowest = lowest;
		b.highest = highest;
		b.residue = residue;
		due.push_back(b);
	endfunction

	function void push_word(logic [15:0] w);
		loader_beat_t b;
		logic [15:0]  follow;
		follow = last_addr + alrp_pkg::ADDR_STEP;
		b.grp = ((word_addr & alrp_pkg::GROUP_MASK) == 16'd0) || (word_addr != follow)
			|| record_first;
		if (word_addr < lowest && word_addr > floor_addr) begin
			lowest = word_addr;
		end
		if (word_addr > highest) begin
			highest = word_addr;
		end
		b.ev = alrp_pkg::EV_WORD;
		b.addr = word_addr;
		b.word = w;
		b.rec = records_done;
		b.lowest = lowest;
		b.highest = highest;
		b.residue = 8'd0;
		last_addr = word_addr;
		word_addr = word_addr + alrp_pkg::ADDR_STEP;
		record_first = 1'b0;
		due.push_back(b);
	endfunction

	function void take_byte(logic [7:0] b);
		if (stopped) begin
			return;
		end
		if (stage == alrp_pkg::PH_START) begin
			csum = 8'd0;
		end
		csum = csum + b;
		case (stage)
			alrp_pkg::PH_START: begin
				if (b == alrp_pkg::END_BYTE) begin
					push_event(alrp_pkg::EV_END, 8'd0);
					stopped = 1'b1;
				end else begin
					stage = (b == alrp_pkg::START_BYTE) ? alrp_pkg::PH_ZERO
						: alrp_pkg::PH_ZERO_BAD;
				end
			end
			alrp_pkg::PH_ZERO, alrp_pkg::PH_ZERO_BAD: begin
				if (stage == alrp_pkg::PH_ZERO_BAD || b != 8'd0) begin
					push_event(alrp_pkg::EV_HDR, 8'd0);
					stopped = 1'b1;
				end else begin
					stage = alrp_pkg::PH_CNT_LO;
				end
			end
			alrp_pkg::PH_CNT_LO: begin
				remaining = {8'd0, b};
				stage = alrp_pkg::PH_CNT_HI;
			end
			alrp_pkg::PH_CNT_HI: begin
				remaining[15:8] = b;
				stage = alrp_pkg::PH_ADR_LO;
			end
			alrp_pkg::PH_ADR_LO: begin
				word_addr = {8'd0, b};
				stage = alrp_pkg::PH_ADR_HI;
			end
			alrp_pkg::PH_ADR_HI: begin
				word_addr[15:8] = b;
				if (word_addr[0]) begin
					push_event(alrp_pkg::EV_ODD, 8'd0);
					stopped = 1'b1;
				end else if (remaining < alrp_pkg::HDR_BYTES) begin
					push_event(alrp_pkg::EV_HDR, 8'd0);
					stopped = 1'b1;
				end else begin
					remaining = remaining - alrp_pkg::HDR_BYTES;
					record_first = 1'b1;
					stage = (remaining != 16'd0) ? alrp_pkg::PH_DATA_LO
						: alrp_pkg::PH_CHECK;
				end
			end
			alrp_pkg::PH_DATA_LO: begin
				remaining = remaining - 16'd1;
				if (remaining == 16'd0) begin
					push_word({8'd0, b});
					stage = alrp_pkg::PH_CHECK;
				end else begin
					low_half = b;
					stage = alrp_pkg::PH_DATA_HI;
				end
			end
			alrp_pkg::PH_DATA_HI: begin
				remaining = remaining - 16'd1;
				push_word({b, low_half});
				stage = (remaining != 16'd0) ? alrp_pkg::PH_DATA_LO : alrp_pkg::PH_CHECK;
			end
			alrp_pkg::PH_CHECK: begin
				if (csum != 8'd0) begin
					push_event(alrp_pkg::EV_SUM, csum);
					stopped = 1'b1;
				end else begin
					push_event(alrp_pkg::EV_OK, 8'd0);
					records_done = records_done + 16'd1;
					stage = alrp_pkg::PH_START;
				end
			end
			default: begin
				stage = alrp_pkg::PH_START;
			end
		endcase
	endfunction

	function void compare(string name, logic [15:0] e, logic [15:0] a);
		if (a !== e) begin
			$display("%0t: %s expected %0h got %0h", $time, name, e, a);
			errors++;
		end
	endfunction

	function void check_beat(loader_beat_t got);
		loader_beat_t e;
		if (due.size() == 0) begin
			$display("%0t: result beat with nothing expected, event %0d address %0h",
				$time, got.ev, got.addr);
			errors++;
			return;
		end
		e = due.pop_front();
		compare("event_res", 16'(e.ev), 16'(got.ev));
		compare("load_address", e.addr, got.addr);
		compare("word_value", e.word, got.word);
		compare("new_group", 16'(e.grp), 16'(got.grp));
		compare("record_number", e.rec, got.rec);
		compare("lowest_address", e.lowest, got.lowest);
		compare("highest_address", e.highest, got.highest);
		compare("sum_residue", 16'(e.residue), 16'(got.residue));
	endfunction
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   byte_total = 0;

	record_parser_checker chk = new();

	alrp_byte_if bytes_ch();
	alrp_cfg_if  cfg_ch();
	alrp_res_if  res_ch();

	absolute_loader_record_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.cfg     (cfg_ch),
		.results (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : monitor
		loader_beat_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				chk.floor_addr = cfg_ch.min_address_floor;
			end
			if (bytes_ch.valid && bytes_ch.ready) begin
				chk.take_byte(bytes_ch.data_byte);
			end
			if (res_ch.valid && res_ch.ready) begin
				got.ev = alrp_pkg::event_t'(res_ch.event_res);
				got.addr = res_ch.load_address;
				got.word = res_ch.word_value;
				got.grp = res_ch.new_group;
				got.rec = res_ch.record_number;
				got.lowest = res_ch.lowest_address;
				got.highest = res_ch.highest_address;
				got.residue = res_ch.sum_residue;
				chk.check_beat(got);
			end
		end
	end

	task automatic set_mode(int m);
		case (m)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 62;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 62;
			end
			default: begin
				idle_pct = 9;
				stall_pct = 9;
			end
		endcase
	endtask

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		do @(posedge clk); while (!bytes_ch.ready);
		byte_total++;
	endtask

	task automatic drain(int limit);
		int n;
		n = 0;
		bytes_ch.valid <= 1'b0;
		while (chk.due.size() != 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_floor(logic [15:0] v);
		drain(100000);
		cfg_ch.valid <= 1'b1;
		cfg_ch.min_address_floor <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_record(logic [15:0] addr, int n, bit bad_sum);
		logic [7:0]  rec[$];
		logic [7:0]  s;
		logic [15:0] cnt;
		cnt = alrp_pkg::HDR_BYTES + 16'(n);
		rec = {alrp_pkg::START_BYTE, 8'd0, cnt[7:0], cnt[15:8], addr[7:0], addr[15:8]};
		repeat (n) begin
			case ($urandom_range(9))
				0: rec.push_back(8'h00);
				1: rec.push_back(8'hFF);
				default: rec.push_back(8'($urandom));
			endcase
		end
		s = 8'd0;
		foreach (rec[i]) s = s + rec[i];
		s = -s;
		if (bad_sum) begin
			s = s + 8'($urandom_range(1, 255));
		end
		rec.push_back(s);
		foreach (rec[i]) send_byte(rec[i]);
	endtask

	initial begin : stimulus
		logic [15:0] addr;
		logic [15:0] next_addr;
		int          n;
		int          rec_idx;
		stop_kind_t  stop;
		arst_n <= 1'b0;
		bytes_ch.valid <= 1'b0;
		bytes_ch.data_byte <= 8'd0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.min_address_floor <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_floor(16'hFFFF);
		send_record(16'h0000, 0, 1'b0);
		send_record(16'hFFFC, 5, 1'b0);
		send_record(16'h0004, 3, 1'b0);

		write_floor(16'h0000);
		next_addr = 16'h0100;
		rec_idx = 0;
		while (byte_total < 1100) begin
			if (rec_idx % 5 == 0) begin
				set_mode((rec_idx / 5) % 4);
			end
			if (rec_idx % 10 == 0 && rec_idx != 0) begin
				case ($urandom_range(3))
					0: write_floor(16'h0000);
					1: write_floor(16'hFFFF);
					2: write_floor(16'($urandom));
					default: write_floor(16'($urandom_range(0, 16'h2000)));
				endcase
			end
			if (rec_idx == 12) begin
				n = 300;
			end else if ($urandom_range(9) == 0) begin
				n = $urandom_range(15, 40);
			end else begin
				n = $urandom_range(0, 14);
			end
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6: addr = next_addr;
				7, 8, 9: addr = 16'hFFE0 | 16'($urandom_range(0, 31));
				default: addr = 16'($urandom);
			endcase
			addr[0] = 1'b0;
			send_record(addr, n, 1'b0);
			next_addr = addr + 16'(2 * ((n + 1) / 2));
			rec_idx++;
		end

		// Any of these stops the parser for good, so one is picked per run.
		stop = stop_kind_t'($urandom_range(5));
		case (stop)
			STOP_END: begin
				send_byte(alrp_pkg::END_BYTE);
			end
			STOP_BAD_FIRST: begin
				send_byte(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(3, 255)));
				send_byte(8'($urandom));
			end
			STOP_BAD_ZERO: begin
				send_byte(alrp_pkg::START_BYTE);
				send_byte(8'($urandom_range(1, 255)));
			end
			STOP_SHORT: begin
				send_byte(alrp_pkg::START_BYTE);
				send_byte(8'd0);
				send_byte(8'($urandom_range(0, 5)));
				send_byte(8'd0);
				send_byte(8'($urandom) & 8'hFE);
				send_byte(8'($urandom));
			end
			STOP_ODD: begin
				send_byte(alrp_pkg::START_BYTE);
				send_byte(8'd0);
				send_byte(8'($urandom));
				send_byte(8'($urandom));
				send_byte(8'($urandom) | 8'h01);
				send_byte(8'($urandom));
			end
			default: begin
				send_record(16'($urandom) & 16'hFFFE, $urandom_range(0, 9), 1'b1);
			end
		endcase
		repeat (4) send_byte(8'($urandom));

		drain(100000);
		if (chk.due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, chk.due.size());
			chk.errors++;
		end
		if (chk.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
src/alrp_pkg.sv
src/alrp_ifs.sv
src/alrp_step.sv
src/absolute_loader_record_parser.sv
tb/tb_top.sv
